// ----- hw/rtl/ail_pkg.sv -----
// shared types and constants for the analog input linearizer
`default_nettype none
package ail_pkg;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned VAL_W = 48;
  localparam int unsigned RAW_W = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIG_OFFSET    = 3'd0,
    REG_SIG_GAIN      = 3'd1,
    REG_SENSOR_MODE   = 3'd2,
    REG_SENSOR_C0     = 3'd3,
    REG_SENSOR_C1     = 3'd4,
    REG_SENSOR_C2     = 3'd5,
    REG_FILTER_ALPHA  = 3'd6,
    REG_SAMPLE_FORMAT = 3'd7
  } cfg_reg_t;

  localparam logic [2:0] MODE_PASS  = 3'd0;
  localparam logic [2:0] MODE_LIN   = 3'd1;
  localparam logic [2:0] MODE_QUAD  = 3'd2;
  localparam logic [2:0] MODE_ROOT  = 3'd3;
  localparam logic [2:0] MODE_SROOT = 3'd4;

  localparam logic [2:0] FMT_I8  = 3'd0;
  localparam logic [2:0] FMT_U8  = 3'd1;
  localparam logic [2:0] FMT_I16 = 3'd2;
  localparam logic [2:0] FMT_U16 = 3'd3;
  localparam logic [2:0] FMT_I24 = 3'd4;
  localparam logic [2:0] FMT_U24 = 3'd5;
  localparam logic [2:0] FMT_I32 = 3'd6;

  localparam logic signed [VAL_W-1:0] POS_LIM = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] NEG_LIM = {1'b1, {(VAL_W-1){1'b0}}};

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DECODE,   // decode raw, form signal value
    OP_LIN,      // c0 + c1*raw
    OP_MUL,      // acc = sat(mul(x, y)), three partial steps then write
    OP_ADD,      // acc = sat(acc + addend)
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_ROOT_FIX, // apply sign after root scale
    OP_ROOT_CLR, // root of a negative argument answers zero
    OP_FILT,
    OP_COMMIT
  } op_t;

  typedef enum logic [2:0] {
    SEL_SIG, SEL_ACC, SEL_C1, SEL_C2, SEL_ROOT, SEL_C0
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t mul_a;
    sel_t mul_b;
    sel_t add_b;
  } dp_cmd_t;

  typedef struct packed {
    logic root_done;
    logic mul_done;
  } dp_status_t;

  // decode raw sample word
  function automatic logic signed [RAW_W-1:0] decode_raw(input logic [31:0] w,
                                                         input logic [3:0] fmt);
    logic [31:0] sw;
    logic [15:0] h;
    logic [23:0] t;
    logic signed [RAW_W-1:0] r;
    sw = {w[7:0], w[15:8], w[23:16], w[31:24]};
    h = fmt[3] ? {w[7:0], w[15:8]} : w[15:0];
    t = fmt[3] ? {w[7:0], w[15:8], w[23:16]} : w[23:0];
    case (fmt[2:0])
      FMT_I8:  r = RAW_W'(signed'(w[7:0]));
      FMT_U8:  r = RAW_W'(w[7:0]);
      FMT_I16: r = RAW_W'(signed'(h));
      FMT_U16: r = RAW_W'(h);
      FMT_I24: r = RAW_W'(signed'(t));
      FMT_U24: r = RAW_W'(t);
      FMT_I32: r = RAW_W'(signed'(fmt[3] ? sw : w));
      default: r = {1'b0, (fmt[3] ? sw : w)};
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/ail_stream_if.sv -----
// valid/ready channel interface
`default_nettype none
interface ail_stream_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ail_datapath.sv -----
// arithmetic datapath: decode, multiply, add, root and filter
`default_nettype none
module ail_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [31:0]             raw_word,
  input  wire logic                    load,
  input  wire ail_pkg::dp_cmd_t        cmd,
  output ail_pkg::dp_status_t          status,
  input  wire logic [31:0]             sig_offset,
  input  wire logic [31:0]             sig_gain,
  input  wire logic [31:0]             sensor_c0,
  input  wire logic [31:0]             sensor_c1,
  input  wire logic [31:0]             sensor_c2,
  input  wire logic [15:0]             filter_alpha,
  input  wire logic [3:0]              sample_format,
  output logic signed [ail_pkg::RAW_W-1:0] raw_value,
  output logic signed [ail_pkg::VAL_W-1:0] signal_value,
  output logic signed [ail_pkg::VAL_W-1:0] actual_value
);
  import ail_pkg::*;
  localparam int unsigned RW = 36;          // root result width
  localparam int unsigned RIT = 36;         // iterations, two radicand bits each
  localparam int unsigned RADW = 2 * RIT;
  localparam int unsigned CW = $clog2(RIT + 1);

  logic [31:0] word;
  logic signed [VAL_W-1:0] acc, last;
  logic signed [VAL_W-1:0] ma, mb, ad;
  logic [RADW-1:0] rad;
  logic [RW+1:0] rem;
  logic [RW-1:0] root;
  logic [CW-1:0] cnt;
  logic tneg;

  function automatic logic signed [VAL_W-1:0] sel(input sel_t s);
    case (s)
      SEL_SIG:  return signal_value;
      SEL_ACC:  return acc;
      SEL_C1:   return VAL_W'(signed'(sensor_c1));
      SEL_C2:   return VAL_W'(signed'(sensor_c2));
      SEL_ROOT: return VAL_W'(root);
      default:  return VAL_W'(signed'(sensor_c0));
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [VAL_W+1:0] v);
    if (v > (VAL_W+2)'(POS_LIM)) return POS_LIM;
    if (v < (VAL_W+2)'(NEG_LIM)) return NEG_LIM;
    return v[VAL_W-1:0];
  endfunction

  // fixed point product built from three 48x16 partial products,
  // magnitude truncated then signed, saturated
  logic [VAL_W-1:0] ua, ub;
  logic [15:0] ub_part;
  logic [VAL_W+15:0] pp;
  logic [2*VAL_W-1:0] pp_sh;
  logic [2*VAL_W-1:0] pacc;
  logic [2*VAL_W-1:0] psh;
  logic signed [VAL_W-1:0] mres;
  logic [1:0] mcnt;
  always_comb begin
    ma = sel(cmd.mul_a);
    mb = sel(cmd.mul_b);
    ad = sel(cmd.add_b);
    ua = ma[VAL_W-1] ? VAL_W'(-ma) : ma;
    ub = mb[VAL_W-1] ? VAL_W'(-mb) : mb;
    case (mcnt)
      2'd0:    ub_part = ub[15:0];
      2'd1:    ub_part = ub[31:16];
      default: ub_part = ub[VAL_W-1 -: 16];
    endcase
    pp = (VAL_W+16)'(ua) * (VAL_W+16)'(ub_part);
    case (mcnt)
      2'd0:    pp_sh = (2*VAL_W)'(pp);
      2'd1:    pp_sh = (2*VAL_W)'(pp) << 16;
      default: pp_sh = (2*VAL_W)'(pp) << 32;
    endcase
    psh = pacc >> FRAC_BITS;
    if (psh > (2*VAL_W)'(POS_LIM)) begin
      mres = (ma[VAL_W-1] ^ mb[VAL_W-1]) ? NEG_LIM : POS_LIM;
    end else if (ma[VAL_W-1] ^ mb[VAL_W-1]) begin
      mres = -signed'(psh[VAL_W-1:0]);
    end else begin
      mres = psh[VAL_W-1:0];
    end
  end

  logic [RW+1:0] trial;
  logic [RW+1:0] rem_sh;
  always_comb begin
    rem_sh = {rem[RW-1:0], rad[RADW-1 -: 2]};
    trial = {root, 2'b01};
  end

  logic signed [VAL_W+1:0] dlt;
  logic [VAL_W:0] dmag;
  logic [VAL_W+16:0] stp;
  logic signed [VAL_W+1:0] fsum;
  logic signed [65:0] sigw, linw;
  logic signed [RAW_W-1:0] rdec;
  always_comb begin
    rdec = decode_raw(word, sample_format);
    sigw = 66'(signed'(sig_offset)) + 66'(signed'(sig_gain)) * 66'(rdec);
    linw = 66'(signed'(sensor_c0)) + 66'(signed'(sensor_c1)) * 66'(raw_value);
    dlt = (VAL_W+2)'(acc) - (VAL_W+2)'(last);
    dmag = dlt[VAL_W+1] ? (VAL_W+1)'(-dlt) : (VAL_W+1)'(dlt);
    stp = ((VAL_W+17)'(dmag) * (VAL_W+17)'(filter_alpha)) >> 16;
    fsum = dlt[VAL_W+1] ? (VAL_W+2)'(last) - (VAL_W+2)'(stp)
                        : (VAL_W+2)'(last) + (VAL_W+2)'(stp);
  end

  function automatic logic signed [VAL_W-1:0] sat66(input logic signed [65:0] v);
    if (v > 66'(POS_LIM)) return POS_LIM;
    if (v < 66'(NEG_LIM)) return NEG_LIM;
    return v[VAL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (load) word <= raw_word;
    case (cmd.op)
      OP_DECODE: begin
        raw_value <= rdec;
        signal_value <= sat66(sigw);
        acc <= sat66(sigw);
      end
      OP_LIN: acc <= sat66(linw);
      OP_MUL: begin
        if (mcnt == 2'd3) acc <= mres;
        else pacc <= ((mcnt == 2'd0) ? '0 : pacc) + pp_sh;
      end
      OP_ADD: acc <= sat((VAL_W+2)'(acc) + (VAL_W+2)'(ad));
      OP_ROOT_INIT: begin
        tneg <= acc[VAL_W-1];
        rad <= RADW'({(acc[VAL_W-1] ? VAL_W'(-acc) : acc), FRAC_BITS'(0)});
        rem <= '0;
        root <= '0;
        cnt <= '0;
      end
      OP_ROOT_STEP: begin
        rad <= rad << 2;
        cnt <= cnt + 1'b1;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          root <= {root[RW-2:0], 1'b0};
        end
      end
      OP_ROOT_FIX: acc <= tneg ? sat(-(VAL_W+2)'(acc)) : acc;
      OP_ROOT_CLR: if (tneg) acc <= '0;
      OP_FILT: if (filter_alpha != '0) acc <= fsum[VAL_W-1:0];
      OP_COMMIT: begin
        actual_value <= acc;
      end
      default: ;
    endcase
    if (rst) last <= '0;
    else if (cmd.op == OP_COMMIT) last <= acc;
    // partial product step counter, wraps back to zero after the write
    if (rst) mcnt <= '0;
    else if (cmd.op == OP_MUL) mcnt <= mcnt + 1'b1;
  end

  assign status.root_done = (cnt == CW'(RIT));
  assign status.mul_done = (mcnt == 2'd3);
endmodule
`default_nettype wire

// ----- hw/rtl/ail_ctrl.sv -----
// sequencing state machine for one sample
`default_nettype none
module ail_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic                out_ready,
  input  wire logic [2:0]          sensor_mode,
  input  wire ail_pkg::dp_status_t status,
  output ail_pkg::dp_cmd_t         cmd,
  output logic                     busy,
  output logic                     out_valid
);
  import ail_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MODE, S_Q1, S_Q2, S_Q3, S_Q4, S_R1, S_R2, S_RI, S_RS,
    S_RM, S_RF, S_FILT, S_COMMIT, S_OUT
  } state_t;
  state_t state;
  logic mode_sroot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) state <= S_DEC;
        S_DEC: state <= S_MODE;
        S_MODE: begin
          case (sensor_mode) inside
            MODE_QUAD: state <= S_Q1;
            MODE_ROOT, MODE_SROOT: state <= S_R1;
            default: state <= S_FILT;
          endcase
        end
        S_Q1: if (status.mul_done) state <= S_Q2;
        S_Q2: state <= S_Q3;
        S_Q3: if (status.mul_done) state <= S_Q4;
        S_Q4: state <= S_FILT;
        S_R1: if (status.mul_done) state <= S_R2;
        S_R2: state <= S_RI;
        S_RI: state <= S_RS;
        S_RS: if (status.root_done) state <= S_RM;
        S_RM: if (status.mul_done) state <= S_RF;
        S_RF: state <= S_FILT;
        S_FILT: state <= S_COMMIT;
        S_COMMIT: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mode_sroot = (sensor_mode == MODE_SROOT);

  always_comb begin
    cmd = '{op: OP_NONE, mul_a: SEL_SIG, mul_b: SEL_SIG, add_b: SEL_C0};
    unique case (state)
      S_DEC: cmd.op = OP_DECODE;
      S_MODE: if (sensor_mode == MODE_LIN) cmd.op = OP_LIN;
      S_Q1: begin cmd.op = OP_MUL; cmd.mul_a = SEL_SIG; cmd.mul_b = SEL_C2; end
      S_Q2: begin cmd.op = OP_ADD; cmd.add_b = SEL_C1; end
      S_Q3: begin cmd.op = OP_MUL; cmd.mul_a = SEL_SIG; cmd.mul_b = SEL_ACC; end
      S_Q4: begin cmd.op = OP_ADD; cmd.add_b = SEL_C0; end
      S_R1: begin cmd.op = OP_MUL; cmd.mul_a = SEL_C1; cmd.mul_b = SEL_SIG; end
      S_R2: begin cmd.op = OP_ADD; cmd.add_b = SEL_C0; end
      S_RI: cmd.op = OP_ROOT_INIT;
      S_RS: if (!status.root_done) cmd.op = OP_ROOT_STEP;
      S_RM: begin cmd.op = OP_MUL; cmd.mul_a = SEL_C2; cmd.mul_b = SEL_ROOT; end
      S_RF: cmd.op = mode_sroot ? OP_ROOT_FIX : OP_ROOT_CLR;
      S_FILT: cmd.op = OP_FILT;
      S_COMMIT: cmd.op = OP_COMMIT;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

// ----- hw/rtl/analog_input_linearizer.sv -----
// top level of the analog input linearizer
`default_nettype none
// one sample at a time; the next item is taken only after the result has been
// accepted, so it is held back while the result waits; the sequence length is
// set by the 36-step bit-serial root and the multiplies built from three
// partial products in the datapath
// rst is synchronous: registers go to their listed values, filter state to zero
module analog_input_linearizer #(
  parameter int unsigned FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  ail_stream_if.sink   in_ch,
  ail_stream_if.source out_ch,
  input wire logic                              cfg_we,
  input wire logic [ail_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input wire logic [ail_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ail_pkg::*;

  // configuration registers
  logic [31:0] sig_offset, sig_gain, sensor_c0, sensor_c1, sensor_c2;
  logic [2:0]  sensor_mode;
  logic [15:0] filter_alpha;
  logic [3:0]  sample_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_offset <= '0;
      sig_gain <= 32'(1) << FRAC_BITS;
      sensor_mode <= MODE_PASS;
      sensor_c0 <= '0;
      sensor_c1 <= '0;
      sensor_c2 <= '0;
      filter_alpha <= '0;
      sample_format <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_SIG_OFFSET:    sig_offset <= cfg_data;
        REG_SIG_GAIN:      sig_gain <= cfg_data;
        REG_SENSOR_MODE:   sensor_mode <= cfg_data[2:0];
        REG_SENSOR_C0:     sensor_c0 <= cfg_data;
        REG_SENSOR_C1:     sensor_c1 <= cfg_data;
        REG_SENSOR_C2:     sensor_c2 <= cfg_data;
        REG_FILTER_ALPHA:  filter_alpha <= cfg_data[15:0];
        REG_SAMPLE_FORMAT: sample_format <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // control and datapath
  dp_cmd_t cmd;
  dp_status_t status;
  logic busy, out_valid, in_fire;
  logic signed [RAW_W-1:0] raw_value;
  logic signed [VAL_W-1:0] signal_value, actual_value;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && !busy;

  ail_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_ready(out_ch.ready), .sensor_mode,
    .status, .cmd, .busy, .out_valid
  );

  ail_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .raw_word(in_ch.data[31:0]), .load(in_fire), .cmd, .status,
    .sig_offset, .sig_gain, .sensor_c0, .sensor_c1, .sensor_c2,
    .filter_alpha, .sample_format, .raw_value, .signal_value, .actual_value
  );

  // result item: raw, signal, actual packed high to low
  assign out_ch.valid = out_valid;
  assign out_ch.data = {raw_value, signal_value, actual_value};
endmodule
`default_nettype wire

// ----- hw/rtl/ail_checker.sv -----
// port-level checks for the analog input linearizer
`default_nettype none
module ail_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [128:0] out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready during result");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("not busy after accept");
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid) else $error("result after reset");
endmodule

bind analog_input_linearizer ail_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ----- tb/sv/tb_analog_input_linearizer.sv -----
// self-checking testbench for the analog input linearizer
`default_nettype none
module tb_analog_input_linearizer;
  timeunit 1ns;
  timeprecision 1ps;
  import ail_pkg::*;

  // codes the package does not name
  localparam logic [2:0] FMT_U32     = 3'd7;
  localparam logic [3:0] FMT_BIG     = 4'h8;
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int unsigned FRAC       = 16;
  localparam int unsigned OUT_W      = RAW_W + 2 * VAL_W;
  localparam int          SETTLE     = 60;   // longest latency (root modes) plus margin

  typedef struct packed {
    logic signed [RAW_W-1:0] raw;
    logic signed [VAL_W-1:0] sig;
    logic signed [VAL_W-1:0] act;
  } sample_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ail_stream_if #(.W(32))    in_ch ();
  ail_stream_if #(.W(OUT_W)) out_ch ();

  analog_input_linearizer #(.FRAC_BITS(FRAC)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the register file and the filter state
  logic signed [31:0] m_offset, m_gain, m_c0, m_c1, m_c2;
  logic [2:0]         m_mode;
  logic [15:0]        m_alpha;
  logic [3:0]         m_fmt;
  logic signed [VAL_W-1:0] m_last;

  sample_res_t expected_results[$];
  int idle_pct  = 0;   // sender idle probability, percent
  int stall_pct = 0;   // receiver stall probability, percent
  int errors    = 0;
  int n_items   = 0;
  int n_checked = 0;

  // ---------------------------------------------------------------------------
  // fixed-point helpers, all done at 128 bits so nothing wraps
  // ---------------------------------------------------------------------------
  function automatic logic signed [VAL_W-1:0] clamp48(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF_FFFF) return POS_LIM;
    if (v < -128'sh8000_0000_0000) return NEG_LIM;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic [127:0] abs128(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // product of two q values, magnitude truncated, sign applied, saturated
  function automatic logic signed [VAL_W-1:0] qmul(input logic signed [127:0] a,
                                                   input logic signed [127:0] b);
    logic [127:0] p;
    logic         neg;
    p   = (abs128(a) * abs128(b)) >> FRAC;
    neg = (a < 0) != (b < 0);
    if (neg) return (p >= 128'h8000_0000_0000) ? NEG_LIM : VAL_W'(-p);
    return (p > 128'h7FFF_FFFF_FFFF) ? POS_LIM : VAL_W'(p);
  endfunction

  // floor(sqrt(v * 2^FRAC)), bit-serial
  function automatic logic signed [VAL_W-1:0] qroot(input logic [127:0] v);
    logic [127:0] rad, rem, root, trial;
    rad  = v << FRAC;
    rem  = '0;
    root = '0;
    for (int k = 35; k >= 0; k--) begin
      rem   = (rem << 2) | ((rad >> (2 * k)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return VAL_W'(root);
  endfunction

  function automatic logic signed [RAW_W-1:0] unpack_sample(input logic [31:0] w);
    logic [7:0] b0, b1, b2, b3;
    logic       big;
    b0  = w[7:0];
    b1  = w[15:8];
    b2  = w[23:16];
    b3  = w[31:24];
    big = (m_fmt & FMT_BIG) != 0;
    case (m_fmt[2:0])
      FMT_I8:  return RAW_W'($signed(b0));
      FMT_U8:  return RAW_W'(b0);
      FMT_I16: return RAW_W'($signed(big ? {b0, b1} : {b1, b0}));
      FMT_U16: return RAW_W'(big ? {b0, b1} : {b1, b0});
      FMT_I24: return RAW_W'($signed(big ? {b0, b1, b2} : {b2, b1, b0}));
      FMT_U24: return RAW_W'(big ? {b0, b1, b2} : {b2, b1, b0});
      FMT_I32: return RAW_W'($signed(big ? {b0, b1, b2, b3} : w));
      default: return {1'b0, (big ? {b0, b1, b2, b3} : w)};
    endcase
  endfunction

  // expected result for one accepted sample; advances the filter state
  function automatic sample_res_t linearize(input logic [31:0] w);
    sample_res_t r;
    logic signed [127:0] raw, sig, act, t, d;
    logic [127:0] stp;
    raw = unpack_sample(w);
    sig = clamp48(128'(signed'(m_offset)) + 128'(signed'(m_gain)) * raw);
    case (m_mode)
      MODE_LIN: act = clamp48(128'(signed'(m_c0)) + 128'(signed'(m_c1)) * raw);
      MODE_QUAD: begin
        act = clamp48(qmul(sig, m_c2) + m_c1);
        act = clamp48(qmul(sig, act) + m_c0);
      end
      MODE_ROOT: begin
        t   = clamp48(m_c0 + qmul(m_c1, sig));
        act = (t >= 0) ? qmul(m_c2, qroot(t)) : 128'sd0;
      end
      MODE_SROOT: begin
        t = clamp48(m_c0 + qmul(m_c1, sig));
        if (t >= 0) act = qmul(m_c2, qroot(t));
        else act = clamp48(-qmul(m_c2, qroot(abs128(t))));
      end
      default: act = sig;
    endcase
    if (m_alpha != 0) begin
      d   = act - m_last;
      stp = (abs128(d) * m_alpha) >> 16;
      act = (d < 0) ? m_last - stp : m_last + stp;
    end
    m_last = act[VAL_W-1:0];
    r.raw  = raw[RAW_W-1:0];
    r.sig  = sig[VAL_W-1:0];
    r.act  = act[VAL_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // receiver back-pressure, changes on the falling edge
  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  // one sample item: optional idle gap, then hold until accepted
  task automatic send_sample(input logic [31:0] w);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(linearize(w));
    n_items++;
  endtask

  // drop valid and wait until every result has come back, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write; only called with the block idle
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_SIG_OFFSET:   m_offset = v;
      REG_SIG_GAIN:     m_gain   = v;
      REG_SENSOR_MODE:  m_mode   = v[2:0];
      REG_SENSOR_C0:    m_c0     = v;
      REG_SENSOR_C1:    m_c1     = v;
      REG_SENSOR_C2:    m_c2     = v;
      REG_FILTER_ALPHA: m_alpha  = v[15:0];
      default:          m_fmt    = v[3:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(input logic [31:0] off, gain, input logic [2:0] mode,
                            input logic [31:0] c0, c1, c2, input logic [15:0] alpha,
                            input logic [3:0] fmt);
    drain();
    write_reg(REG_SIG_OFFSET, off);
    write_reg(REG_SIG_GAIN, gain);
    write_reg(REG_SENSOR_MODE, 32'(mode));
    write_reg(REG_SENSOR_C0, c0);
    write_reg(REG_SENSOR_C1, c1);
    write_reg(REG_SENSOR_C2, c2);
    write_reg(REG_FILTER_ALPHA, 32'(alpha));
    write_reg(REG_SAMPLE_FORMAT, 32'(fmt));
  endtask

  // ---------------------------------------------------------------------------
  // checker: every result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_res_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result raw=%0d sig=%0d act=%0d", $time,
                 got.raw, got.sig, got.act);
        errors++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (got.raw !== want.raw) begin
          $display("%0t: raw_value expected %0d got %0d", $time, want.raw, got.raw);
          errors++;
        end
        if (got.sig !== want.sig) begin
          $display("%0t: signal_value expected %0d got %0d", $time, want.sig, got.sig);
          errors++;
        end
        if (got.act !== want.act) begin
          $display("%0t: actual_value expected %0d got %0d", $time, want.act, got.act);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // every width, signedness and byte order, sign bits (but for little-endian I32) and unused upper bytes set
  task automatic test_sample_formats();
    for (int f = 0; f < 16; f++) begin
      load_setup(32'd0, 32'h0001_0000, MODE_PASS, 0, 0, 0, 16'd0, 4'(f));
      send_sample((f % 2) ? 32'hFFFF_FFFF : 32'h5A80_8081);
    end
  endtask

  // each sensor mode other than pass, incl. root of a negative value, the spare modes and saturation
  task automatic test_sensor_modes();
    load_setup(32'h8000_0000, 32'h7FFF_FFFF, MODE_LIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               0, 16'd0, {1'b0, FMT_U32});
    send_sample(32'hFFFF_FFFF);
    load_setup(32'h0000_8000, 32'h0000_4000, MODE_QUAD, 32'h0001_0000, 32'hFFFF_0000,
               32'h0000_2000, 16'd0, {1'b0, FMT_I16});
    send_sample(32'h0000_1234);
    load_setup(0, 32'h0001_0000, MODE_ROOT, 32'h0000_0000, 32'h0001_0000,
               32'h0002_0000, 16'd0, {1'b0, FMT_I16});
    send_sample(32'h0000_0019);  // positive argument
    send_sample(32'h0000_FFE7);  // negative argument answers zero
    drain();
    write_reg(REG_SENSOR_MODE, 32'(MODE_SROOT));
    send_sample(32'h0000_FFE7);  // negative argument, signed root
    drain();
    write_reg(REG_SENSOR_C2, 32'h8000_0000);
    send_sample(32'h0000_8000);
    drain();
    write_reg(REG_SENSOR_MODE, 32'(MODE_SPARE5));
    send_sample(32'h0000_0042);
    drain();
    write_reg(REG_SENSOR_MODE, 32'(MODE_SPARE7));
    send_sample(32'h0000_7FFF);
  endtask

  // low-pass with the largest and smallest ratio, both step directions
  task automatic test_filter();
    load_setup(0, 32'h0001_0000, MODE_PASS, 0, 0, 0, 16'hFFFF, {1'b0, FMT_I16});
    send_sample(32'h0000_7FFF);
    send_sample(32'h0000_8000);
    drain();
    write_reg(REG_FILTER_ALPHA, 32'h0000_0001);
    send_sample(32'h0000_7FFF);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 9)) inside
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      [3:5]:   return $urandom_range(0, 4 * 65536) * ($urandom_range(0, 1) ? 1 : -1);
      default: return $urandom;
    endcase
  endfunction

  // random setups, each followed by a burst of random words
  task automatic test_random(input int idle, input int stall, input int count);
    int sent;
    logic [15:0] alpha;
    sent      = 0;
    drain();
    idle_pct  = idle;
    stall_pct = stall;
    while (sent < count) begin
      case ($urandom_range(0, 3))
        0:       alpha = 16'd0;
        1:       alpha = 16'hFFFF;
        default: alpha = 16'($urandom);
      endcase
      load_setup(pick_coef(), pick_coef(), 3'($urandom_range(0, 7)), pick_coef(),
                 pick_coef(), pick_coef(), alpha, 4'($urandom_range(0, 15)));
      for (int i = 0; i < 50 && sent < count; i++) begin
        send_sample($urandom);
        sent++;
        // hold the sender back until the pipe is empty, then carry on
        if (i == 25 && $urandom_range(0, 3) == 0) drain();
      end
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_idx     <= REG_SIG_OFFSET;
    cfg_data    <= '0;
    m_offset = 0; m_gain = 32'h0001_0000; m_mode = MODE_PASS;
    m_c0 = 0; m_c1 = 0; m_c2 = 0; m_alpha = 0; m_fmt = 0; m_last = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_sample_formats();
    test_sensor_modes();
    test_filter();
    test_random(0, 0, 375);
    test_random(78, 0, 375);
    test_random(0, 78, 375);
    test_random(32, 32, 375);
    drain();

    $display("covered all sample formats, sensor modes incl. spare codes and negative roots,");
    $display("filter on and off; %0d items sent, %0d results checked", n_items, n_checked);
    if (errors == 0) begin
      $display("[analog_input_linearizer] OK");
    end else begin
      $display("[analog_input_linearizer] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("[analog_input_linearizer] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
